@@ design/cef_pkg.sv @@
// Package with shared constants, mode codes and the notice text for the console log filter.
`default_nettype none
package cef_pkg;

    localparam int SPIN_LINE_DEPTH = 32;
    localparam int MAX_PARAMS      = 16;
    localparam int SPIN_ADDR_W     = $clog2(SPIN_LINE_DEPTH);
    localparam int SPIN_LEN_W      = $clog2(SPIN_LINE_DEPTH + 1);
    localparam int PARAM_W         = 4;
    localparam int CR_W            = 16;
    localparam int NOTICE_LEN      = 24;
    localparam int NOTICE_IDX_W    = 5;
    localparam int CNT_W           = (SPIN_LEN_W > NOTICE_IDX_W) ? SPIN_LEN_W : NOTICE_IDX_W;
    localparam int CR_SPIN         = 5;
    localparam int PAL_DIGITS      = 7;

    typedef enum logic [3:0] {
        M_NORMAL  = 4'd0,
        M_ESC     = 4'd1,
        M_SQUARE  = 4'd2,
        M_GETPARS = 4'd3,
        M_GOTPARS = 4'd4,
        M_FUNCKEY = 4'd5,
        M_HASH    = 4'd6,
        M_SETG0   = 4'd7,
        M_SETG1   = 4'd8,
        M_PERCENT = 4'd9,
        M_NONSTD  = 4'd11,
        M_PALETTE = 4'd12
    } esc_mode_t;

    function automatic logic [7:0] notice_byte(input logic [NOTICE_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h0A;
            5'd1:    b = "<";
            5'd2:    b = "p";
            5'd3:    b = "r";
            5'd4:    b = "o";
            5'd5:    b = "g";
            5'd6:    b = "r";
            5'd7:    b = "e";
            5'd8:    b = "s";
            5'd9:    b = "s";
            5'd10:   b = " ";
            5'd11:   b = "b";
            5'd12:   b = "a";
            5'd13:   b = "r";
            5'd14:   b = " ";
            5'd15:   b = "s";
            5'd16:   b = "k";
            5'd17:   b = "i";
            5'd18:   b = "p";
            5'd19:   b = "p";
            5'd20:   b = "e";
            5'd21:   b = "d";
            5'd22:   b = ">";
            5'd23:   b = 8'h0A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ design/cef_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module cef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ design/console_escape_log_filter_unit.sv @@
// Top level of the console escape log filter: escape decoding, spinner capture and word output.
`default_nettype none
// An input word is accepted only while the sequencer is idle; a word with no output leaves it idle for the next word.
// A word with short results goes to S_SEQ, which loads them into the output register in order while the output is free.
// A spinner line flush reads the line store through its one read port: each stored byte passes S_RD, then S_PUT.
// The progress notice sends its 24 words from S_NOTE; output stalls on m_ready hold S_PUT, S_SEQ and S_NOTE.
// Synchronous active-low reset clears the sequencer state, escape state, counters and output valid flag.
// The line store has no reset; only entries below the stored length are ever read.
module console_escape_log_filter_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_out_byte,
    output logic            m_run_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_PUT,
        S_SEQ,
        S_NOTE
    } seq_state_t;

    seq_state_t                         state_reg;
    cef_pkg::esc_mode_t                 mode_reg, mode_next;
    logic [cef_pkg::PARAM_W-1:0]        pc_reg, pc_next;
    logic                               als_reg, als_next;
    logic [cef_pkg::CR_W-1:0]           cr_reg, cr_next;
    logic [cef_pkg::CR_W-1:0]           cap_reg, cap_next;
    logic [cef_pkg::SPIN_LEN_W-1:0]     len_reg, len_next;
    logic [cef_pkg::CNT_W-1:0]          cnt_reg;
    logic [7:0]                         seq_buf_reg [4];
    logic [7:0]                         seq_buf_next [4];
    logic [2:0]                         seq_cnt_reg, seq_cnt_next;
    logic                               flush_next, note_next;
    logic                               m_valid_reg;
    logic [7:0]                         m_byte_reg;
    logic                               m_last_reg;

    logic                               accept;
    logic                               out_free;
    logic                               out_load;
    logic                               ram_we;
    logic [cef_pkg::SPIN_ADDR_W-1:0]    ram_waddr;
    logic                               ram_re;
    logic [7:0]                         ram_rdata;
    logic [cef_pkg::CR_W-1:0]           cr_inc;
    logic [cef_pkg::SPIN_LEN_W-1:0]     base_len;
    logic                               is_digit, is_hex;
    logic [7:0]                         c;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = out_free &&
                        (state_reg == S_PUT || state_reg == S_SEQ || state_reg == S_NOTE);
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_run_last = m_last_reg;
    assign c          = s_in_byte;
    assign ram_re     = (state_reg == S_RD);

    cef_ram #(
        .WIDTH(8),
        .DEPTH(cef_pkg::SPIN_LINE_DEPTH)
    ) u_line_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(s_in_byte),
        .rd_en  (ram_re),
        .rd_addr(cnt_reg[cef_pkg::SPIN_ADDR_W-1:0]),
        .rd_data(ram_rdata)
    );

    always_comb begin
        mode_next    = mode_reg;
        pc_next      = pc_reg;
        als_next     = als_reg;
        cr_next      = cr_reg;
        cap_next     = cap_reg;
        len_next     = len_reg;
        seq_cnt_next = 3'd0;
        flush_next   = 1'b0;
        note_next    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        base_len     = len_reg;
        for (int i = 0; i < 4; i++) begin
            seq_buf_next[i] = 8'h0A;
        end
        is_digit = (c >= "0") && (c <= "9");
        is_hex   = is_digit || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
        cr_inc   = (cr_reg == {cef_pkg::CR_W{1'b1}}) ? cr_reg : cr_reg + 1'b1;

        case (mode_reg)
            cef_pkg::M_ESC: begin
                mode_next = cef_pkg::M_NORMAL;
                if (c == "[") begin
                    mode_next = cef_pkg::M_SQUARE;
                end else if (c == "]") begin
                    mode_next = cef_pkg::M_NONSTD;
                end else if (c == "%") begin
                    mode_next = cef_pkg::M_PERCENT;
                end else if (c == "E" || c == "D") begin
                    flush_next   = (cr_reg > cef_pkg::CR_W'(4)) && (len_reg != '0);
                    als_next     = 1'b1;
                    cr_next      = '0;
                    seq_cnt_next = 3'd1;
                end else if (c == "(") begin
                    mode_next = cef_pkg::M_SETG0;
                end else if (c == ")") begin
                    mode_next = cef_pkg::M_SETG1;
                end else if (c == "#") begin
                    mode_next = cef_pkg::M_HASH;
                end
            end
            cef_pkg::M_NONSTD: begin
                if (c == "P") begin
                    pc_next   = '0;
                    mode_next = cef_pkg::M_PALETTE;
                end else begin
                    mode_next = cef_pkg::M_NORMAL;
                end
            end
            cef_pkg::M_PALETTE: begin
                if (is_hex) begin
                    pc_next = pc_reg + 1'b1;
                    if (pc_next == cef_pkg::PARAM_W'(cef_pkg::PAL_DIGITS)) begin
                        mode_next = cef_pkg::M_NORMAL;
                    end
                end else begin
                    mode_next = cef_pkg::M_NORMAL;
                end
            end
            cef_pkg::M_SQUARE, cef_pkg::M_GETPARS: begin
                if (mode_reg == cef_pkg::M_SQUARE) begin
                    pc_next = '0;
                end
                if (mode_reg == cef_pkg::M_SQUARE && c == "[") begin
                    mode_next = cef_pkg::M_FUNCKEY;
                end else if (mode_reg == cef_pkg::M_SQUARE && c == "?") begin
                    mode_next = cef_pkg::M_GETPARS;
                end else if (c == ";" &&
                             pc_next < cef_pkg::PARAM_W'(cef_pkg::MAX_PARAMS - 1)) begin
                    pc_next   = pc_next + 1'b1;
                    mode_next = cef_pkg::M_GETPARS;
                end else if (is_digit) begin
                    mode_next = cef_pkg::M_GETPARS;
                end else begin
                    mode_next = cef_pkg::M_NORMAL;
                end
            end
            cef_pkg::M_GOTPARS, cef_pkg::M_PERCENT, cef_pkg::M_FUNCKEY,
            cef_pkg::M_HASH, cef_pkg::M_SETG0, cef_pkg::M_SETG1: begin
                mode_next = cef_pkg::M_NORMAL;
            end
            default: begin
                mode_next = cef_pkg::M_NORMAL;
                if (c <= 8'd8 || (c >= 8'd16 && c <= 8'd23) || c == 8'd25 ||
                    (c >= 8'd28 && c <= 8'd31)) begin
                    als_next        = 1'b0;
                    cr_next         = '0;
                    seq_buf_next[0] = "^";
                    seq_buf_next[1] = c + 8'd64;
                    seq_cnt_next    = 3'd2;
                end else if (c == 8'd10) begin
                    flush_next   = (cr_reg > cef_pkg::CR_W'(4)) && (len_reg != '0);
                    als_next     = 1'b1;
                    cr_next      = '0;
                    seq_cnt_next = 3'd1;
                end else if (c == 8'd13) begin
                    cr_next = cr_inc;
                    if (cr_inc < cef_pkg::CR_W'(cef_pkg::CR_SPIN)) begin
                        if (cr_inc > cef_pkg::CR_W'(1)) begin
                            seq_cnt_next = 3'd1;
                        end
                        als_next = 1'b1;
                    end
                    note_next = (cr_inc == cef_pkg::CR_W'(cef_pkg::CR_SPIN));
                end else if (c == 8'd14 || c == 8'd15 || c == 8'd24 || c == 8'd26) begin
                    cr_next = '0;
                end else if (c == 8'd27) begin
                    cr_next   = '0;
                    mode_next = cef_pkg::M_ESC;
                end else if (c == 8'd9 || (c >= 8'd32 && c <= 8'd126) || c >= 8'd160) begin
                    if (cr_reg < cef_pkg::CR_W'(cef_pkg::CR_SPIN)) begin
                        if (cr_reg == cef_pkg::CR_W'(1) && als_reg) begin
                            seq_buf_next[1] = c;
                            seq_cnt_next    = 3'd2;
                        end else begin
                            seq_buf_next[0] = c;
                            seq_cnt_next    = 3'd1;
                        end
                    end else begin
                        if (cap_reg != cr_reg) begin
                            cap_next = cr_reg;
                            base_len = '0;
                        end
                        len_next = base_len;
                        if (base_len < cef_pkg::SPIN_LEN_W'(cef_pkg::SPIN_LINE_DEPTH)) begin
                            ram_we    = accept;
                            ram_waddr = base_len[cef_pkg::SPIN_ADDR_W-1:0];
                            len_next  = base_len + 1'b1;
                        end
                    end
                    als_next = 1'b0;
                end else if (c == 8'd127) begin
                    als_next        = 1'b0;
                    cr_next         = '0;
                    seq_buf_next[0] = "^";
                    seq_buf_next[1] = "?";
                    seq_cnt_next    = 3'd2;
                end else if (c == 8'd155) begin
                    cr_next   = '0;
                    mode_next = cef_pkg::M_SQUARE;
                end else if (c >= 8'd128 && c <= 8'd159) begin
                    als_next        = 1'b0;
                    cr_next         = '0;
                    seq_buf_next[0] = "\\";
                    seq_buf_next[1] = "0" + {6'd0, c[7:6]};
                    seq_buf_next[2] = "0" + {5'd0, c[5:3]};
                    seq_buf_next[3] = "0" + {5'd0, c[2:0]};
                    seq_cnt_next    = 3'd4;
                end else begin
                    als_next        = 1'b0;
                    cr_next         = '0;
                    seq_buf_next[0] = "0";
                    seq_buf_next[1] = "x";
                    seq_buf_next[2] = (c == 8'd11) ? "B" : "C";
                    seq_cnt_next    = 3'd3;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= cef_pkg::M_NORMAL;
            pc_reg      <= '0;
            als_reg     <= 1'b0;
            cr_reg      <= '0;
            cap_reg     <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            seq_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        mode_reg    <= mode_next;
                        pc_reg      <= pc_next;
                        als_reg     <= als_next;
                        cr_reg      <= cr_next;
                        cap_reg     <= cap_next;
                        len_reg     <= len_next;
                        seq_buf_reg <= seq_buf_next;
                        seq_cnt_reg <= seq_cnt_next;
                        cnt_reg     <= '0;
                        if (note_next) begin
                            state_reg <= S_NOTE;
                        end else if (flush_next) begin
                            state_reg <= S_RD;
                        end else if (seq_cnt_next != 3'd0) begin
                            state_reg <= S_SEQ;
                        end
                    end
                end
                S_RD: begin
                    state_reg <= S_PUT;
                end
                S_PUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_byte_reg  <= ram_rdata;
                        m_last_reg  <= 1'b0;
                        if ((cnt_reg + 1'b1) == cef_pkg::CNT_W'(len_reg)) begin
                            cnt_reg   <= '0;
                            state_reg <= S_SEQ;
                        end else begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SEQ: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_byte_reg  <= seq_buf_reg[cnt_reg[1:0]];
                        if (cnt_reg == cef_pkg::CNT_W'(seq_cnt_reg - 3'd1)) begin
                            m_last_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end else begin
                            m_last_reg <= 1'b0;
                            cnt_reg    <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_NOTE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_byte_reg  <= cef_pkg::notice_byte(cnt_reg[cef_pkg::NOTICE_IDX_W-1:0]);
                        if (cnt_reg == cef_pkg::CNT_W'(cef_pkg::NOTICE_LEN - 1)) begin
                            m_last_reg <= 1'b1;
                            state_reg  <= S_IDLE;
                        end else begin
                            m_last_reg <= 1'b0;
                            cnt_reg    <= cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The stored length never exceeds the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= cef_pkg::SPIN_LEN_W'(cef_pkg::SPIN_LINE_DEPTH))
        else $error("line store length beyond depth");

    // A flush only reads entries below the stored length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (cef_pkg::SPIN_LEN_W'(cnt_reg) < len_reg))
        else $error("flush read beyond stored length");

    // The store is never written while a flush is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_IDLE))
        else $error("line store written outside idle");

    // The first notice word is always a newline and is not marked as the last word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NOTE && cnt_reg == '0 && out_free) |=>
        (m_valid && m_out_byte == 8'h0A && !m_run_last))
        else $error("notice did not start with a newline");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the console escape log filter: directed and random byte streams, checked word by word.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 200;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SO  = 8'h0E;
    localparam logic [7:0] CH_SI  = 8'h0F;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_SUB = 8'h1A;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CSI = 8'h9B;

    localparam logic [8*cef_pkg::NOTICE_LEN-1:0] SKIP_NOTE = "\n<progress bar skipped>\n";

    typedef enum int {
        SEQ_TEXT, SEQ_CSI, SEQ_FUNC_KEY, SEQ_PALETTE, SEQ_OSC_OTHER, SEQ_CHARSET,
        SEQ_ESC_SINGLE, SEQ_SPINNER, SEQ_NEWLINE, SEQ_NOISE, SEQ_CONTROL, SEQ_BROKEN
    } seq_kind_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_run_last;

    console_escape_log_filter_unit u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Filter state as seen from outside.
    cef_pkg::esc_mode_t              mode;
    logic [cef_pkg::PARAM_W-1:0]     npar;
    logic                            line_start;
    logic [cef_pkg::CR_W-1:0]        cr_cnt;
    logic [cef_pkg::CR_W-1:0]        cap_cr;
    logic [cef_pkg::SPIN_LEN_W-1:0]  spin_len;
    logic [7:0]                      spin_buf [cef_pkg::SPIN_LINE_DEPTH];

    logic [7:0]  step_q [$];
    logic [7:0]  exp_byte [$];
    logic        exp_last [$];
    logic [8:0]  pend_q [$];

    bit          drain_next = 1'b0;
    bit          idle_on = 1'b1;
    bit          hold_start = 1'b0;
    bit          hold_done = 1'b0;
    bit          word_taken = 1'b0;
    int          queued = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int unsigned cycles = 0;

    task automatic line_break();
        if (cr_cnt > 4) begin
            for (int i = 0; i < spin_len; i++) step_q.push_back(spin_buf[i]);
        end
        line_start = 1'b1;
        cr_cnt = '0;
        step_q.push_back(CH_LF);
    endtask

    task automatic plain_byte(input logic [7:0] c);
        mode = cef_pkg::M_NORMAL;
        if (c <= 8 || (c >= 16 && c <= 23) || c == 25 || (c >= 28 && c <= 31)) begin
            line_start = 1'b0;
            cr_cnt = '0;
            step_q.push_back("^");
            step_q.push_back(c + 8'd64);
        end else if (c == CH_LF) begin
            line_break();
        end else if (c == CH_CR) begin
            if (cr_cnt != 16'hFFFF) cr_cnt = cr_cnt + 1'b1;
            if (cr_cnt < cef_pkg::CR_SPIN) begin
                if (cr_cnt > 1) step_q.push_back(CH_LF);
                line_start = 1'b1;
            end
            if (cr_cnt == cef_pkg::CR_SPIN) begin
                for (int i = 0; i < cef_pkg::NOTICE_LEN; i++)
                    step_q.push_back(SKIP_NOTE[8*(cef_pkg::NOTICE_LEN-1-i) +: 8]);
            end
        end else if (c == CH_SO || c == CH_SI || c == CH_CAN || c == CH_SUB) begin
            cr_cnt = '0;
        end else if (c == CH_ESC) begin
            cr_cnt = '0;
            mode = cef_pkg::M_ESC;
        end else if (c == CH_TAB || (c >= 32 && c <= 126) || c >= 160) begin
            if (cr_cnt < cef_pkg::CR_SPIN) begin
                if (cr_cnt == 1 && line_start) step_q.push_back(CH_LF);
                step_q.push_back(c);
            end else begin
                if (cap_cr != cr_cnt) begin
                    cap_cr = cr_cnt;
                    spin_len = '0;
                end
                if (spin_len < cef_pkg::SPIN_LINE_DEPTH) begin
                    spin_buf[spin_len] = c;
                    spin_len = spin_len + 1'b1;
                end
            end
            line_start = 1'b0;
        end else if (c == CH_DEL) begin
            line_start = 1'b0;
            cr_cnt = '0;
            step_q.push_back("^");
            step_q.push_back("?");
        end else if (c == CH_CSI) begin
            cr_cnt = '0;
            mode = cef_pkg::M_SQUARE;
        end else if (c >= 128 && c <= 159) begin
            line_start = 1'b0;
            cr_cnt = '0;
            step_q.push_back("\\");
            step_q.push_back("0" + c[7:6]);
            step_q.push_back("0" + c[5:3]);
            step_q.push_back("0" + c[2:0]);
        end else begin
            line_start = 1'b0;
            cr_cnt = '0;
            step_q.push_back("0");
            step_q.push_back("x");
            step_q.push_back(c == CH_VT ? "B" : "C");
        end
    endtask

    task automatic csi_param(input logic [7:0] c);
        if (c == ";" && npar < cef_pkg::MAX_PARAMS - 1) begin
            npar = npar + 1'b1;
            mode = cef_pkg::M_GETPARS;
        end else if (c >= "0" && c <= "9") begin
            mode = cef_pkg::M_GETPARS;
        end else begin
            mode = cef_pkg::M_NORMAL;
        end
    endtask

    task automatic filter_byte(input logic [7:0] c);
        step_q.delete();
        case (mode)
            cef_pkg::M_ESC: begin
                mode = cef_pkg::M_NORMAL;
                if (c == "[") mode = cef_pkg::M_SQUARE;
                else if (c == "]") mode = cef_pkg::M_NONSTD;
                else if (c == "%") mode = cef_pkg::M_PERCENT;
                else if (c == "E" || c == "D") line_break();
                else if (c == "(") mode = cef_pkg::M_SETG0;
                else if (c == ")") mode = cef_pkg::M_SETG1;
                else if (c == "#") mode = cef_pkg::M_HASH;
            end
            cef_pkg::M_NONSTD: begin
                if (c == "P") begin
                    npar = '0;
                    mode = cef_pkg::M_PALETTE;
                end else begin
                    mode = cef_pkg::M_NORMAL;
                end
            end
            cef_pkg::M_PALETTE: begin
                if ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
                    (c >= "a" && c <= "f")) begin
                    npar = npar + 1'b1;
                    if (npar == cef_pkg::PAL_DIGITS) mode = cef_pkg::M_NORMAL;
                end else begin
                    mode = cef_pkg::M_NORMAL;
                end
            end
            cef_pkg::M_SQUARE: begin
                npar = '0;
                if (c == "[") mode = cef_pkg::M_FUNCKEY;
                else if (c == "?") mode = cef_pkg::M_GETPARS;
                else csi_param(c);
            end
            cef_pkg::M_GETPARS: csi_param(c);
            cef_pkg::M_GOTPARS, cef_pkg::M_PERCENT, cef_pkg::M_FUNCKEY, cef_pkg::M_HASH,
            cef_pkg::M_SETG0, cef_pkg::M_SETG1: mode = cef_pkg::M_NORMAL;
            default: plain_byte(c);
        endcase
        foreach (step_q[i]) begin
            exp_byte.push_back(step_q[i]);
            exp_last.push_back(i == step_q.size() - 1);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        pend_q.push_back({drain_next, b});
        drain_next = 1'b0;
        queued++;
    endtask

    function automatic logic [7:0] random_print();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return CH_TAB;
        if (r < 3) return 8'($urandom_range(160, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic queue_sequence();
        seq_kind_t kind;
        int        reps;
        int        r;
        kind = seq_kind_t'($urandom_range(0, SEQ_BROKEN));
        drain_next = ($urandom_range(0, 11) == 0);
        case (kind)
            SEQ_TEXT: repeat ($urandom_range(1, 12)) queue_byte(random_print());
            SEQ_CSI: begin
                if ($urandom_range(0, 1) == 0) begin
                    queue_byte(CH_CSI);
                end else begin
                    queue_byte(CH_ESC);
                    queue_byte("[");
                end
                if ($urandom_range(0, 3) == 0) queue_byte("?");
                repeat ($urandom_range(0, 18)) begin
                    if ($urandom_range(0, 2) != 0) queue_byte(";");
                    else queue_byte(8'("0" + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 3) == 0) queue_byte(8'($urandom_range(0, 255)));
                else queue_byte(8'($urandom_range(64, 126)));
            end
            SEQ_FUNC_KEY: begin
                queue_byte(CH_ESC);
                queue_byte("[");
                queue_byte("[");
                queue_byte(8'($urandom_range(0, 255)));
            end
            SEQ_PALETTE: begin
                queue_byte(CH_ESC);
                queue_byte("]");
                queue_byte("P");
                repeat ($urandom_range(0, 9)) begin
                    r = $urandom_range(0, 21);
                    queue_byte(r < 10 ? 8'("0" + r) :
                               r < 16 ? 8'("A" + r - 10) : 8'("a" + r - 16));
                end
                if ($urandom_range(0, 1) == 0) queue_byte(random_print());
            end
            SEQ_OSC_OTHER: begin
                queue_byte(CH_ESC);
                queue_byte("]");
                queue_byte(8'($urandom_range(0, 255)));
            end
            SEQ_CHARSET: begin
                queue_byte(CH_ESC);
                case ($urandom_range(0, 3))
                    0: queue_byte("(");
                    1: queue_byte(")");
                    2: queue_byte("#");
                    default: queue_byte("%");
                endcase
                queue_byte(8'($urandom_range(0, 255)));
            end
            SEQ_ESC_SINGLE: begin
                queue_byte(CH_ESC);
                r = $urandom_range(0, 2);
                if (r == 0) queue_byte("D");
                else if (r == 1) queue_byte("E");
                else queue_byte(8'($urandom_range(0, 255)));
            end
            SEQ_SPINNER: begin
                reps = $urandom_range(1, 8);
                for (int i = 0; i < reps; i++) begin
                    queue_byte(CH_CR);
                    repeat ($urandom_range(0, 5) == 0 ? 40 : $urandom_range(0, 12))
                        queue_byte(random_print());
                end
                r = $urandom_range(0, 3);
                if (r == 0) begin
                    queue_byte(CH_LF);
                end else if (r < 3) begin
                    queue_byte(CH_ESC);
                    queue_byte(r == 1 ? "D" : "E");
                end
            end
            SEQ_NEWLINE: queue_byte(CH_LF);
            SEQ_NOISE: repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
            SEQ_CONTROL: begin
                r = $urandom_range(0, 3);
                if (r == 0) queue_byte(8'($urandom_range(0, 31)));
                else if (r == 1) queue_byte(CH_DEL);
                else if (r == 2) queue_byte(8'($urandom_range(128, 159)));
                else queue_byte($urandom_range(0, 1) == 0 ? CH_VT : CH_FF);
            end
            default: begin
                queue_byte(CH_ESC);
                if ($urandom_range(0, 1) == 0) queue_byte("[");
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic drained();
        do begin
            @(posedge aclk);
            #1;
        end while (pend_q.size() != 0 || s_valid || exp_byte.size() != 0);
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("console_escape_log_filter_unit test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin : monitor
        logic [7:0] eb;
        logic       el;
        word_taken = aresetn && s_valid && s_ready;
        if (word_taken) filter_byte(s_in_byte);
        if (aresetn && m_valid && m_ready) begin
            if (exp_byte.size() == 0) begin
                $display("%0t: unexpected word out_byte %02h run_last %0b",
                         $time, m_out_byte, m_run_last);
                mismatches++;
            end else begin
                eb = exp_byte.pop_front();
                el = exp_last.pop_front();
                if (m_out_byte !== eb) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time, eb, m_out_byte);
                    mismatches++;
                end
                if (m_run_last !== el) begin
                    $display("%0t: run_last expected %0b actual %0b", $time, el, m_run_last);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge aclk) begin : driver
        logic       nv;
        logic [8:0] it;
        nv = s_valid;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (!s_valid || word_taken) begin
            nv = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (pend_q.size() != 0 && !(pend_q[0][8] && exp_byte.size() != 0)) begin
                if (idle_on && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 7);
                end else begin
                    it = pend_q.pop_front();
                    nv = 1'b1;
                    s_in_byte <= it[7:0];
                end
            end
        end
        s_valid <= nv;
    end

    always @(negedge aclk) begin : sink
        if (!aresetn || (hold_start && !hold_done)) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : sink_hold
        wait (hold_start);
        repeat (LONG_HOLD) @(posedge aclk);
        hold_done = 1'b1;
    end

    initial begin : stimulus
        int target;
        mode = cef_pkg::M_NORMAL;
        npar = '0;
        line_start = 1'b0;
        cr_cnt = '0;
        cap_cr = '0;
        spin_len = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        #1;

        drain_next = 1'b1;
        repeat (6) queue_byte(CH_CR);
        queue_byte(CH_LF);
        drain_next = 1'b1;
        queue_byte(8'h00);
        queue_byte(8'h1F);
        queue_byte(CH_TAB);
        queue_byte(" ");
        queue_byte("~");
        queue_byte(CH_DEL);
        queue_byte(8'h80);
        queue_byte(8'h9F);
        queue_byte(8'hA0);
        queue_byte(8'hFF);
        queue_byte(CH_VT);
        queue_byte(CH_FF);
        queue_byte(CH_SO);
        queue_byte(CH_ESC);
        queue_byte("[");
        repeat (16) queue_byte(";");
        queue_byte("X");
        drain_next = 1'b1;
        repeat (5) queue_byte(CH_CR);
        repeat (cef_pkg::SPIN_LINE_DEPTH + 2) queue_byte(random_print());
        queue_byte(CH_ESC);
        queue_byte("E");
        repeat (5) queue_byte(CH_CR);
        queue_byte(CH_LF);
        drained();

        hold_start = 1'b1;
        repeat (40) queue_byte(8'($urandom_range(128, 154)));
        drained();

        for (int chunk = 0; chunk < 5; chunk++) begin
            idle_on = (chunk != 2);
            target = queued + 16;
            while (queued < target) queue_sequence();
            drained();
        end

        idle_on = 1'b0;
        target = queued + 16;
        while (queued < target) queue_sequence();
        drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && exp_byte.size() == 0) begin
            $display("console_escape_log_filter_unit test passed");
        end else begin
            $display("console_escape_log_filter_unit test failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
design/cef_pkg.sv
design/cef_ram.sv
design/console_escape_log_filter_unit.sv
verif/tb.sv
